>>> sv/tts_pkg.sv
package tts_pkg;

  localparam logic [2:0] OP_CREATE   = 3'd0;
  localparam logic [2:0] OP_SUSPEND  = 3'd1;
  localparam logic [2:0] OP_RESUME   = 3'd2;
  localparam logic [2:0] OP_KILL     = 3'd3;
  localparam logic [2:0] OP_KILL_ALL = 3'd4;
  localparam logic [2:0] OP_FIND     = 3'd5;
  localparam logic [2:0] OP_COMPLETE = 3'd6;

  localparam int MAX_SLOTS = 8;
  localparam int TICK_W = 16;
  localparam int IN_W   = 56;
  localparam int OUT_W  = 8;

  function automatic logic in_window(input logic [TICK_W-1:0] d,
                                     input logic [TICK_W-1:0] s,
                                     input logic [TICK_W-1:0] e);
    if (s <= e) begin
      return (d >= s) && (d < e);
    end
    return (d >= s) || (d < e);
  endfunction

endpackage

>>> sv/tick_task_scheduler_unit.sv
// Channel   Dir  Handshake                  Payload (low bit first)
// s_axis    in   s_axis_tvalid/tready       opcode, task_id, interval, from_tick, to_tick
// m_axis    out  m_axis_tvalid/tready       ok, slot, active_count
//
// A request runs from the accept in ST_IDLE through decode and slot update in ST_EXEC, then
// a load (ST_LOAD) and a check (ST_CHECK) per created slot, task_count as it stands after
// decode, through the due-tick memory read port and the shared window/compare unit, and
// ends in ST_DONE, which loads the result register; with no task ST_LOAD goes to ST_DONE.
// rst clears all flags and the task count; the due-tick memory is not cleared.
// s_axis_tready is high only while idle; a waiting result stalls the next one in its last cycle.
module tick_task_scheduler_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // opcode[2:0], task_id[5:3], interval[21:6], from_tick[37:22], to_tick[53:38]
  input  logic [tts_pkg::IN_W-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // ok[0], slot[3:1], active_count[7:4]
  output logic [tts_pkg::OUT_W-1:0] m_axis_tdata
);
  import tts_pkg::*;

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_CHECK,
    ST_DONE
  } state_t;

  state_t state;

  logic [2:0]        req_op;
  logic [2:0]        req_id;
  logic [TICK_W-1:0] req_ivl;
  logic [TICK_W-1:0] req_start;
  logic [TICK_W-1:0] req_end;

  logic [MAX_SLOTS-1:0] skip_flag;
  logic [MAX_SLOTS-1:0] suspend_flag;
  logic [MAX_SLOTS-1:0] exit_flag;
  logic [CNT_W-1:0]     task_count;

  logic [SLOT_W-1:0] idx;
  logic [CNT_W-1:0]  live_cnt;
  logic              ok_r;
  logic [SLOT_W-1:0] res_slot;

  logic [TICK_W-1:0] due_mem [MAX_SLOTS];
  logic [TICK_W-1:0] due_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  logic [TICK_W-1:0] mem_wd;

  logic              known;
  logic              create_ok;
  logic [SLOT_W-1:0] id_ix;
  logic [SLOT_W-1:0] new_ix;
  logic              stopped;
  logic              hit_window;
  logic              last_slot;

  assign s_axis_tready = (state == ST_IDLE);

  assign id_ix      = SLOT_W'(req_id);
  assign new_ix     = SLOT_W'(task_count);
  assign known      = 32'(req_id) < 32'(task_count);
  assign create_ok  = 32'(task_count) < 32'(MAX_SLOTS);
  assign stopped    = suspend_flag[idx] | exit_flag[idx];
  assign hit_window = in_window(due_q, req_start, req_end);
  assign last_slot  = (CNT_W'(idx) + CNT_W'(1)) == task_count;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = id_ix;
    mem_wd = 16'(req_end + req_ivl);
    if (state == ST_EXEC) begin
      if (req_op == OP_CREATE) begin
        mem_we = create_ok;
        mem_wa = new_ix;
        mem_wd = '0;
      end else if (req_op == OP_COMPLETE) begin
        mem_we = known;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      due_mem[mem_wa] <= mem_wd;
    end
    due_q <= due_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      skip_flag     <= '0;
      suspend_flag  <= '0;
      exit_flag     <= '0;
      task_count    <= '0;
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
      live_cnt      <= '0;
      ok_r          <= 1'b0;
      res_slot      <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            req_op    <= s_axis_tdata[2:0];
            req_id    <= s_axis_tdata[5:3];
            req_ivl   <= s_axis_tdata[21:6];
            req_start <= s_axis_tdata[37:22];
            req_end   <= s_axis_tdata[53:38];
            state     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          ok_r     <= 1'b0;
          res_slot <= '0;
          idx      <= '0;
          live_cnt <= '0;
          unique case (req_op)
            OP_CREATE: begin
              if (create_ok) begin
                skip_flag[new_ix]    <= 1'b1;
                suspend_flag[new_ix] <= 1'b0;
                exit_flag[new_ix]    <= 1'b0;
                task_count           <= task_count + CNT_W'(1);
                ok_r                 <= 1'b1;
                res_slot             <= new_ix;
              end
            end
            OP_SUSPEND: begin
              if (known && !exit_flag[id_ix] && !suspend_flag[id_ix]) begin
                suspend_flag[id_ix] <= 1'b1;
                ok_r                <= 1'b1;
              end
            end
            OP_RESUME: begin
              if (known && !exit_flag[id_ix] && suspend_flag[id_ix]) begin
                suspend_flag[id_ix] <= 1'b0;
                skip_flag[id_ix]    <= 1'b1;
                ok_r                <= 1'b1;
              end
            end
            OP_KILL: begin
              if (known && !exit_flag[id_ix]) begin
                exit_flag[id_ix] <= 1'b1;
                ok_r             <= 1'b1;
              end
            end
            OP_KILL_ALL: begin
              ok_r <= 1'b1;
            end
            OP_COMPLETE: begin
              if (known) begin
                if (req_ivl == '0) begin
                  exit_flag[id_ix] <= 1'b1;
                end
                skip_flag[id_ix] <= 1'b0;
                ok_r             <= 1'b1;
              end
            end
            default: begin
            end
          endcase
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= (task_count == '0) ? ST_DONE : ST_CHECK;
        end
        ST_CHECK: begin
          if (req_op == OP_KILL_ALL) begin
            exit_flag[idx] <= 1'b1;
          end else if (!stopped) begin
            live_cnt <= live_cnt + CNT_W'(1);
          end
          if (req_op == OP_FIND && !ok_r && !stopped &&
              (skip_flag[idx] || due_q == req_start)) begin
            skip_flag[idx] <= 1'b0;
            ok_r           <= 1'b1;
            res_slot       <= idx;
          end
          if (req_op == OP_COMPLETE && ok_r && idx != id_ix && !stopped && hit_window) begin
            skip_flag[idx] <= 1'b1;
          end
          if (last_slot) begin
            state <= ST_DONE;
          end else begin
            idx   <= idx + SLOT_W'(1);
            state <= ST_LOAD;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'(live_cnt), 3'(res_slot), ok_r};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a request is in work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(task_count) <= 32'(MAX_SLOTS))
    else $error("task count beyond slot table");

  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 32'(m_axis_tdata[7:4]) <= 32'(task_count))
    else $error("active count exceeds created tasks");
`endif

endmodule

>>> dv/tick_task_scheduler_unit_tb.sv
`timescale 1ns / 100ps

module tick_task_scheduler_unit_tb;
  import tts_pkg::*;

  localparam int SLOTS = MAX_SLOTS;
  localparam int RAND_ITEMS = 1750;
  localparam int LONG_HOLD = 400;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [TICK_W-1:0] to_tick;
    logic [TICK_W-1:0] from_tick;
    logic [TICK_W-1:0] interval;
    logic [2:0]        task_id;
    logic [2:0]        opcode;
  } sched_req_t;

  typedef struct packed {
    logic [3:0] active;
    logic [2:0] slot;
    logic       ok;
  } sched_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // opcode, task_id, interval, from_tick, to_tick
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // ok, slot, active_count
  logic [OUT_W-1:0] m_axis_tdata;

  tick_task_scheduler_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  logic [TICK_W-1:0] due_tick [SLOTS];
  logic [SLOTS-1:0]  skipped = '0;
  logic [SLOTS-1:0]  suspended = '0;
  logic [SLOTS-1:0]  exited = '0;
  int                n_created = 0;

  sched_req_t req_q [$];
  sched_rsp_t result_q [$];
  sched_req_t cur_req;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        recv_hold = 1'b0;

  int n_reqs = 0;
  int n_rsps = 0;
  int n_found = 0;
  int n_completed = 0;
  int n_table_full = 0;
  int n_mismatch = 0;

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  function automatic logic tick_in_window(input logic [TICK_W-1:0] d,
                                          input logic [TICK_W-1:0] s,
                                          input logic [TICK_W-1:0] e);
    logic [TICK_W-1:0] off;
    logic [TICK_W-1:0] span;
    off  = d - s;
    span = e - s;
    return off < span;
  endfunction

  task automatic sched_step(input sched_req_t r, output sched_rsp_t rsp);
    logic known;
    logic [2:0] id;
    rsp   = '0;
    id    = r.task_id;
    known = (int'(id) < n_created);
    case (r.opcode)
      OP_CREATE: begin
        if (n_created < SLOTS) begin
          due_tick[n_created]  = '0;
          skipped[n_created]   = 1'b1;
          suspended[n_created] = 1'b0;
          exited[n_created]    = 1'b0;
          rsp.ok   = 1'b1;
          rsp.slot = 3'(n_created);
          n_created++;
        end else begin
          n_table_full++;
        end
      end
      OP_SUSPEND: begin
        if (known && !exited[id] && !suspended[id]) begin
          suspended[id] = 1'b1;
          rsp.ok = 1'b1;
        end
      end
      OP_RESUME: begin
        if (known && !exited[id] && suspended[id]) begin
          suspended[id] = 1'b0;
          skipped[id]   = 1'b1;
          rsp.ok = 1'b1;
        end
      end
      OP_KILL: begin
        if (known && !exited[id]) begin
          exited[id] = 1'b1;
          rsp.ok = 1'b1;
        end
      end
      OP_KILL_ALL: begin
        for (int i = 0; i < n_created; i++) exited[i] = 1'b1;
        rsp.ok = 1'b1;
      end
      OP_FIND: begin
        for (int i = 0; i < n_created; i++) begin
          if (!rsp.ok && !suspended[i] && !exited[i] &&
              (skipped[i] || due_tick[i] == r.from_tick)) begin
            skipped[i] = 1'b0;
            rsp.ok   = 1'b1;
            rsp.slot = 3'(i);
          end
        end
        if (rsp.ok) n_found++;
      end
      OP_COMPLETE: begin
        if (known) begin
          for (int i = 0; i < n_created; i++) begin
            if (!suspended[i] && !exited[i] &&
                tick_in_window(due_tick[i], r.from_tick, r.to_tick)) begin
              skipped[i] = 1'b1;
            end
          end
          if (r.interval == '0) exited[id] = 1'b1;
          due_tick[id] = r.to_tick + r.interval;
          skipped[id]  = 1'b0;
          rsp.ok = 1'b1;
          n_completed++;
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < n_created; i++) begin
      if (!suspended[i] && !exited[i]) rsp.active = rsp.active + 4'd1;
    end
  endtask

  always @(posedge clk) begin : req_driver
    sched_rsp_t want;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sched_step(cur_req, want);
        result_q.push_back(want);
        n_reqs++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_W - $bits(sched_req_t)){1'b0}}, cur_req};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_checker
    sched_rsp_t got;
    sched_rsp_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        n_rsps++;
        if (result_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("[%0t] result with no request outstanding: ok=%0d slot=%0d active=%0d",
                     $realtime, got.ok, got.slot, got.active);
          end
        end else begin
          want = result_q.pop_front();
          if (got.ok !== want.ok || got.slot !== want.slot ||
              got.active !== want.active) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("[%0t] result %0d: expected ok=%0d slot=%0d active=%0d,",
                       $realtime, n_rsps, want.ok, want.slot, want.active);
              $display("    got ok=%0d slot=%0d active=%0d",
                       got.ok, got.slot, got.active);
            end
          end
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : long_hold
    wait (hold_go);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    recv_hold <= 1'b0;
  end

  initial begin : watchdog
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic sched_req_t mk_req(input logic [2:0] op, input logic [2:0] id,
                                        input logic [TICK_W-1:0] ivl,
                                        input logic [TICK_W-1:0] st,
                                        input logic [TICK_W-1:0] en);
    sched_req_t r;
    r.opcode    = op;
    r.task_id   = id;
    r.interval  = ivl;
    r.from_tick = st;
    r.to_tick   = en;
    return r;
  endfunction

  task automatic push_req(input sched_req_t r);
    while (req_q.size() >= 4) @(negedge clk);
    req_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [2:0] pick_id();
    logic [2:0] id;
    id = 3'($urandom_range(7));
    if (n_created > 0 && $urandom_range(99) < 80) begin
      id = 3'($urandom_range(n_created - 1));
      for (int t = 0; t < 4 && exited[id]; t++) id = 3'($urandom_range(n_created - 1));
    end
    return id;
  endfunction

  function automatic sched_req_t next_random_req(input int idx);
    sched_req_t r;
    int unsigned pick;
    logic tail;
    r.opcode    = OP_UNUSED;
    r.task_id   = 3'($urandom_range(7));
    r.interval  = 16'($urandom_range(65535));
    r.from_tick = 16'($urandom_range(65535));
    r.to_tick   = 16'($urandom_range(65535));
    tail = (idx >= RAND_ITEMS - RAND_ITEMS / 10);
    pick = $urandom_range(99);
    if (idx == RAND_ITEMS - 3) begin
      r.opcode = OP_KILL_ALL;
    end else if (pick < 7) begin
      r.opcode = OP_CREATE;
    end else if (pick < 20) begin
      r.opcode  = OP_SUSPEND;
      r.task_id = pick_id();
    end else if (pick < 33) begin
      r.opcode  = OP_RESUME;
      r.task_id = pick_id();
    end else if (pick < 37) begin
      // slots 0..2 stay exited after the opening sequence
      r.opcode  = OP_KILL;
      r.task_id = tail ? pick_id() : 3'($urandom_range(2));
    end else if (pick < 40) begin
      r.opcode = OP_UNUSED;
    end else if (pick < 70) begin
      r.opcode = OP_FIND;
      if (n_created > 0 && $urandom_range(99) < 60) begin
        r.from_tick = due_tick[$urandom_range(n_created - 1)];
      end
    end else begin
      r.opcode  = OP_COMPLETE;
      r.task_id = pick_id();
      if (tail && $urandom_range(99) < 20) begin
        r.interval = '0;
      end else if ($urandom_range(99) < 70) begin
        r.interval = 16'($urandom_range(40, 1));
      end else begin
        r.interval = 16'($urandom_range(65535, 1));
      end
      if (n_created > 0 && $urandom_range(99) < 50) begin
        r.from_tick = due_tick[$urandom_range(n_created - 1)] - 16'($urandom_range(8));
        r.to_tick   = r.from_tick + 16'($urandom_range(30));
      end
    end
    return r;
  endfunction

  initial begin : stimulus
    int idx;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_req(mk_req(OP_FIND, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_SUSPEND, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_COMPLETE, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_req(mk_req(OP_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_req(mk_req(OP_CREATE, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_CREATE, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_CREATE, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_FIND, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_SUSPEND, 3'd1, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_SUSPEND, 3'd1, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_RESUME, 3'd1, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_RESUME, 3'd1, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_COMPLETE, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_req(mk_req(OP_COMPLETE, 3'd1, 16'h0001, 16'hFFF0, 16'h0010));
    push_req(mk_req(OP_FIND, 3'd0, 16'h0000, 16'h0011, 16'h0000));
    push_req(mk_req(OP_FIND, 3'd0, 16'h0000, 16'h0011, 16'h0000));
    push_req(mk_req(OP_COMPLETE, 3'd2, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_COMPLETE, 3'd2, 16'h0005, 16'h0000, 16'h8000));
    push_req(mk_req(OP_KILL, 3'd1, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_KILL, 3'd1, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_RESUME, 3'd2, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_KILL_ALL, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_FIND, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    push_req(mk_req(OP_SUSPEND, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    wait_drained();

    idx = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      while (idx < (phase + 1) * RAND_ITEMS / 4) begin
        if (phase == 0 && idx == 100) hold_go = 1'b1;
        push_req(next_random_req(idx));
        idx++;
      end
      // hold off the sender until every result is back
      wait_drained();
    end

    repeat (40) @(posedge clk);
    n_mismatch += result_q.size();
    $display("covered %0d requests in four handshake phases with a long output stall,",
             n_reqs);
    $display("%0d results checked; finds that hit %0d, completes taken %0d, full-table creates %0d",
             n_rsps, n_found, n_completed, n_table_full);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
